@@ rtl/core/tetr_pkg.sv @@
// Shared types, event codes and sizes for the touch event report tracker.
package tetr_pkg;

    localparam int VAL_W  = 32;
    localparam int TYPE_W = 16;
    localparam int CODE_W = 16;
    localparam int KIND_W = 2;
    localparam int X_W    = 10;
    localparam int Y_W    = 9;
    localparam int CIDX_W = 2;

    localparam int SCREEN_W_DEF = 640;
    localparam int SCREEN_H_DEF = 480;

    localparam logic [TYPE_W-1:0] EV_SYN = 16'h0000;
    localparam logic [TYPE_W-1:0] EV_KEY = 16'h0001;
    localparam logic [TYPE_W-1:0] EV_ABS = 16'h0003;

    localparam logic [CODE_W-1:0] CODE_FRAME_END  = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_TOUCH_KEY  = 16'h014a;
    localparam logic [CODE_W-1:0] ABS_X           = 16'h0000;
    localparam logic [CODE_W-1:0] ABS_Y           = 16'h0001;
    localparam logic [CODE_W-1:0] CODE_SLOT_SEL   = 16'h002f;
    localparam logic [CODE_W-1:0] CODE_SLOT_X     = 16'h0035;
    localparam logic [CODE_W-1:0] CODE_SLOT_Y     = 16'h0036;
    localparam logic [CODE_W-1:0] CODE_CONTACT_ID = 16'h0039;

    localparam logic [KIND_W-1:0] KIND_DOWN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOTION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UP     = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_X_MIN = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_X_MAX = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_Y_MIN = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_Y_MAX = 2'd3;

    localparam logic signed [VAL_W-1:0] X_MIN_RST = 32'sd0;
    localparam logic signed [VAL_W-1:0] X_MAX_RST = 32'sd639;
    localparam logic signed [VAL_W-1:0] Y_MIN_RST = 32'sd0;
    localparam logic signed [VAL_W-1:0] Y_MAX_RST = 32'sd479;

    typedef struct packed {
        logic [TYPE_W-1:0]       ev_type;
        logic [CODE_W-1:0]       ev_code;
        logic signed [VAL_W-1:0] ev_value;
    } tetr_in_t;

    typedef struct packed {
        logic [KIND_W-1:0] touch_kind;
        logic [X_W-1:0]    touch_x;
        logic [Y_W-1:0]    touch_y;
        logic              run_last;
    } tetr_out_t;

    typedef struct packed {
        logic                    start;
        logic signed [VAL_W-1:0] val;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
    } tetr_scale_req_t;

endpackage

@@ rtl/core/tetr_scale.sv @@
// Iterative clamp, multiply and restoring divide for one axis coordinate.
module tetr_scale
    import tetr_pkg::*;
#(
    parameter int Q_W = 10
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  tetr_scale_req_t req,
    input  logic [Q_W-1:0]  size_m1,
    output logic            done,
    output logic [Q_W-1:0]  q
);

    localparam int CNT_W = $clog2(Q_W + 1);

    localparam logic [2:0] SC_IDLE  = 3'd0;
    localparam logic [2:0] SC_CLAMP = 3'd1;
    localparam logic [2:0] SC_SUB   = 3'd2;
    localparam logic [2:0] SC_MUL   = 3'd3;
    localparam logic [2:0] SC_DIV   = 3'd4;
    localparam logic [2:0] SC_DONE  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [VAL_W-1:0] v_reg, v_next;
    logic signed [VAL_W-1:0] lo_reg, lo_next;
    logic signed [VAL_W-1:0] hi_reg, hi_next;
    logic [VAL_W-1:0]        span_reg, span_next;
    logic [VAL_W-1:0]        rem_reg, rem_next;
    logic [Q_W-1:0]          dv_reg, dv_next;

    logic [VAL_W+Q_W-1:0]    prod;
    logic [VAL_W:0]          trial;
    logic [VAL_W:0]          diff;
    logic                    ge;
    logic [Q_W:0]            dv_shift;

    // offset is unsigned here, so it is zero-extended
    assign prod     = (VAL_W+Q_W)'($unsigned(v_reg)) * (VAL_W+Q_W)'(size_m1);
    assign trial    = {rem_reg, dv_reg[Q_W-1]};
    assign diff     = trial - {1'b0, span_reg};
    assign ge       = trial >= {1'b0, span_reg};
    assign dv_shift = {dv_reg, ge};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        v_next     = v_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        span_next  = span_reg;
        rem_next   = rem_reg;
        dv_next    = dv_reg;
        case (state_reg)
            SC_IDLE:
            begin
                if (req.start)
                begin
                    v_next     = req.val;
                    lo_next    = req.lo;
                    hi_next    = req.hi;
                    state_next = SC_CLAMP;
                end
            end
            SC_CLAMP:
            begin
                if (hi_reg <= lo_reg)
                begin
                    dv_next    = '0;
                    state_next = SC_DONE;
                end
                else
                begin
                    if (v_reg < lo_reg)
                    begin
                        v_next = lo_reg;
                    end
                    else if (v_reg > hi_reg)
                    begin
                        v_next = hi_reg;
                    end
                    state_next = SC_SUB;
                end
            end
            SC_SUB:
            begin
                // offset and span both fit 32 unsigned bits once clamped
                v_next     = v_reg - lo_reg;
                span_next  = VAL_W'(hi_reg - lo_reg);
                state_next = SC_MUL;
            end
            SC_MUL:
            begin
                rem_next   = prod[VAL_W+Q_W-1:Q_W];
                dv_next    = prod[Q_W-1:0];
                cnt_next   = CNT_W'(Q_W);
                state_next = SC_DIV;
            end
            SC_DIV:
            begin
                rem_next = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
                dv_next  = dv_shift[Q_W-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = SC_DONE;
                end
            end
            SC_DONE:
            begin
                state_next = SC_IDLE;
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        span_reg <= span_next;
        rem_reg  <= rem_next;
        dv_reg   <= dv_next;
    end

    assign done = (state_reg == SC_DONE);
    assign q    = dv_reg;

endmodule

@@ rtl/core/touch_event_report_tracker_top.sv @@
// Top level: slot-0 touch tracker turning input events into down/motion/up words.
// Position event: input stalled while the bit-per-cycle divider scales it, Q_W =
//   clog2(max screen size); an empty raw range skips multiply and divide and gives 0.
// Other events need no scaling; a report gives its one or two words one per cycle while
//   out_stall is low, from the output register, input stalled until the last is taken.
// Reset: async active low; slot 0 selected, flags and coordinates cleared,
//   raw ranges back to 0..639 and 0..479.
module touch_event_report_tracker_top
    import tetr_pkg::*;
#(
    parameter int SCREEN_W = SCREEN_W_DEF,
    parameter int SCREEN_H = SCREEN_H_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tetr_in_t           in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output tetr_out_t          out_word,
    input  logic               cfg_we,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [VAL_W-1:0]   cfg_data
);

    localparam int SCREEN_MAX = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
    localparam int Q_W        = $clog2(SCREEN_MAX);
    localparam logic [Q_W-1:0] X_SIZE_M1 = Q_W'(SCREEN_W - 1);
    localparam logic [Q_W-1:0] Y_SIZE_M1 = Q_W'(SCREEN_H - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCALE = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic signed [VAL_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic                    on_first_slot_reg, on_first_slot_next;
    logic                    pend_down_reg, pend_down_next;
    logic                    pend_up_reg, pend_up_next;
    logic                    pos_moved_reg, pos_moved_next;
    logic                    finger_down_reg, finger_down_next;
    logic                    axis_y_reg, axis_y_next;
    logic                    second_reg, second_next;
    logic [X_W-1:0]          cur_x_reg, cur_x_next;
    logic [Y_W-1:0]          cur_y_reg, cur_y_next;
    tetr_out_t               word_reg, word_next;

    tetr_scale_req_t         scl_req;
    logic                    scl_done;
    logic [Q_W-1:0]          scl_q;

    logic                    accept;
    logic                    is_pos_x, is_pos_y;
    logic                    fd_mid, down_vld, first_vld, up_vld;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign is_pos_x = (in_word.ev_type == EV_ABS) && on_first_slot_reg &&
                      (in_word.ev_code inside {CODE_SLOT_X, ABS_X});
    assign is_pos_y = (in_word.ev_type == EV_ABS) && on_first_slot_reg &&
                      (in_word.ev_code inside {CODE_SLOT_Y, ABS_Y});

    assign fd_mid    = finger_down_reg | pend_down_reg;
    assign down_vld  = pend_down_reg & ~finger_down_reg;
    assign first_vld = down_vld | (pos_moved_reg & finger_down_reg);
    assign up_vld    = pend_up_reg & fd_mid;

    assign scl_req.start = accept && (is_pos_x || is_pos_y);
    assign scl_req.val   = in_word.ev_value;
    assign scl_req.lo    = is_pos_y ? y_min_reg : x_min_reg;
    assign scl_req.hi    = is_pos_y ? y_max_reg : x_max_reg;

    tetr_scale #(
        .Q_W (Q_W)
    ) u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scl_req),
        .size_m1 (axis_y_reg ? Y_SIZE_M1 : X_SIZE_M1),
        .done    (scl_done),
        .q       (scl_q)
    );

    always_comb
    begin
        state_next         = state_reg;
        on_first_slot_next = on_first_slot_reg;
        pend_down_next     = pend_down_reg;
        pend_up_next       = pend_up_reg;
        pos_moved_next     = pos_moved_reg;
        finger_down_next   = finger_down_reg;
        axis_y_next        = axis_y_reg;
        second_next        = second_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        word_next          = word_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_word.ev_type)
                        EV_ABS:
                        begin
                            if (in_word.ev_code == CODE_SLOT_SEL)
                            begin
                                on_first_slot_next = (in_word.ev_value == '0);
                            end
                            else if (in_word.ev_code == CODE_CONTACT_ID)
                            begin
                                if (on_first_slot_reg)
                                begin
                                    if (in_word.ev_value >= 0)
                                    begin
                                        pend_down_next = 1'b1;
                                    end
                                    else
                                    begin
                                        pend_up_next = 1'b1;
                                    end
                                end
                            end
                            else if (is_pos_x || is_pos_y)
                            begin
                                axis_y_next = is_pos_y;
                                state_next  = ST_SCALE;
                            end
                        end
                        EV_KEY:
                        begin
                            if (in_word.ev_code == CODE_TOUCH_KEY)
                            begin
                                if (in_word.ev_value != '0)
                                begin
                                    pend_down_next = 1'b1;
                                end
                                else
                                begin
                                    pend_up_next = 1'b1;
                                end
                            end
                        end
                        EV_SYN:
                        begin
                            if (in_word.ev_code == CODE_FRAME_END)
                            begin
                                word_next.touch_x    = cur_x_reg;
                                word_next.touch_y    = cur_y_reg;
                                word_next.touch_kind = first_vld ?
                                    (down_vld ? KIND_DOWN : KIND_MOTION) : KIND_UP;
                                word_next.run_last   = !(first_vld && up_vld);
                                second_next          = first_vld && up_vld;
                                finger_down_next     = fd_mid && !up_vld;
                                pend_down_next       = 1'b0;
                                pend_up_next         = 1'b0;
                                pos_moved_next       = 1'b0;
                                if (first_vld || up_vld)
                                begin
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCALE:
            begin
                if (scl_done)
                begin
                    if (axis_y_reg)
                    begin
                        cur_y_next = Y_W'(scl_q);
                    end
                    else
                    begin
                        cur_x_next = X_W'(scl_q);
                    end
                    pos_moved_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (second_reg)
                    begin
                        word_next.touch_kind = KIND_UP;
                        word_next.run_last   = 1'b1;
                        second_next          = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            x_min_reg         <= X_MIN_RST;
            x_max_reg         <= X_MAX_RST;
            y_min_reg         <= Y_MIN_RST;
            y_max_reg         <= Y_MAX_RST;
            on_first_slot_reg <= 1'b1;
            pend_down_reg     <= 1'b0;
            pend_up_reg       <= 1'b0;
            pos_moved_reg     <= 1'b0;
            finger_down_reg   <= 1'b0;
            axis_y_reg        <= 1'b0;
            second_reg        <= 1'b0;
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            on_first_slot_reg <= on_first_slot_next;
            pend_down_reg     <= pend_down_next;
            pend_up_reg       <= pend_up_next;
            pos_moved_reg     <= pos_moved_next;
            finger_down_reg   <= finger_down_next;
            axis_y_reg        <= axis_y_next;
            second_reg        <= second_next;
            cur_x_reg         <= cur_x_next;
            cur_y_reg         <= cur_y_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_X_MIN: x_min_reg <= cfg_data;
                    CFG_X_MAX: x_max_reg <= cfg_data;
                    CFG_Y_MIN: y_min_reg <= cfg_data;
                    CFG_Y_MAX: y_max_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = (state_reg == ST_EMIT);
    assign out_word  = word_reg;

    a_done_in_scale: assert property (@(posedge clk) disable iff (!rst_n)
        scl_done |-> state_reg == ST_SCALE)
        else $error("scaler finished outside scale state");

    a_up_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_word.run_last) |=>
        (out_valid && out_word.touch_kind == KIND_UP && out_word.run_last))
        else $error("second word of report is not a final up");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_word.run_last) |=> !out_valid)
        else $error("word after last of report");

    a_first_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.run_last) |->
        (out_word.touch_kind == KIND_DOWN || out_word.touch_kind == KIND_MOTION))
        else $error("non-final word is not down or motion");

endmodule
